@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is active (active low).
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    `ASSERT_CLK(lbl, clk, rstn, (ante) |-> (cons))

`endif

@@ hw/rtl/soc_pkg.sv @@
package soc_pkg;

    localparam int COORD_W       = 10;   // input coordinate width
    localparam int POS_W         = 12;   // signed walk position, covers -1023..2046
    localparam int TOTAL_W       = 21;
    localparam int HIT_W         = 2;
    localparam int GRID_SIDE_DEF = 1024;
    localparam int ADDR_W_DEF    = 20;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    // register index, taken from paddr[2]
    localparam logic REG_INCLUDE_DIAG = 1'b0;

    // per-cell hit codes
    localparam logic [HIT_W-1:0] HIT_NONE  = 2'd0;
    localparam logic [HIT_W-1:0] HIT_ONCE  = 2'd1;
    localparam logic [HIT_W-1:0] HIT_MULTI = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_WALK  = 4'b0100,
        ST_FLUSH = 4'b1000
    } t_state;

endpackage

@@ hw/rtl/soc_cell_ram.sv @@
module soc_cell_ram #(
    parameter int ADDR_W = soc_pkg::ADDR_W_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_re,
    input  logic [ADDR_W-1:0]          i_raddr,
    input  logic                       i_we,
    input  logic [ADDR_W-1:0]          i_waddr,
    input  logic [soc_pkg::HIT_W-1:0]  i_wdata,
    output logic [soc_pkg::HIT_W-1:0]  o_rdata
);
    import soc_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    logic [HIT_W-1:0] r_mem [DEPTH];
    logic [HIT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/segment_overlap_counter.sv @@
// Segment overlap counter.
// Input channel: present a segment on i_start_x/i_start_y/i_end_x/i_end_y with
// start high; the item is taken at the clock edge where start is high and busy
// is low. Result channel: o_overlap_cells is valid for one cycle with o_done
// and cannot be held off by the receiver.
// Config: APB port, register include_diagonals at byte address 0 (bit 0).
// Write it only while busy is low and no result is pending.
// Timing: a segment of n cells (n = |dx|+1 or |dy|+1, up to GRID_SIDE) is
// walked in ST_WALK, then passes ST_FLUSH; o_done shows and busy drops in
// the same cycle, so the next item can be taken while the result is shown.
// Throughput is one cell per cycle, set by the read-modify-write pipeline on
// the single grid memory (one read port, one write port). A segment that is
// not rasterized (diagonal with include_diagonals at 0) skips ST_WALK and
// goes straight to ST_FLUSH.
// Reset: synchronous, active low. After reset the block sweeps the grid
// memory to zero, one cell per cycle, all 2^(2*ceil(log2(GRID_SIDE))) cells
// (1,048,576 by default); busy stays high meanwhile, config writes still work.
`include "assert_macros.svh"

module segment_overlap_counter #(
    parameter int GRID_SIDE = soc_pkg::GRID_SIDE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // item input
    input  logic                           start,
    output logic                           busy,
    input  logic [soc_pkg::COORD_W-1:0]    i_start_x,
    input  logic [soc_pkg::COORD_W-1:0]    i_start_y,
    input  logic [soc_pkg::COORD_W-1:0]    i_end_x,
    input  logic [soc_pkg::COORD_W-1:0]    i_end_y,
    // result
    output logic                           o_done,
    output logic [soc_pkg::TOTAL_W-1:0]    o_overlap_cells,
    // config
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [soc_pkg::APB_AW-1:0]     paddr,
    input  logic [soc_pkg::APB_DW-1:0]     pwdata,
    output logic [soc_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);
    import soc_pkg::*;

    localparam int CW     = $clog2(GRID_SIDE);   // bits per grid coordinate
    localparam int ADDR_W = 2 * CW;              // cell address {y, x}
    localparam logic [POS_W:0] SIDE_C = (POS_W+1)'(GRID_SIDE);

    // state
    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic                r_diag;
    logic [TOTAL_W-1:0]  r_total, n_total;

    // walker
    logic [POS_W-1:0]    r_cur_x, n_cur_x;
    logic [POS_W-1:0]    r_cur_y, n_cur_y;
    logic [1:0]          r_step_x, n_step_x;     // two's complement -1/0/+1
    logic [1:0]          r_step_y, n_step_y;
    logic [COORD_W-1:0]  r_left, n_left;         // cells still to walk, minus one

    // read stage -> write stage
    logic                r_s1_vld, n_s1_vld;
    logic [ADDR_W-1:0]   r_s1_addr, n_s1_addr;

    // result
    logic                r_out_vld, n_out_vld;
    logic [TOTAL_W-1:0]  r_out_total, n_out_total;

    // memory port
    logic                ram_re, ram_we;
    logic [ADDR_W-1:0]   ram_raddr, ram_waddr;
    logic [HIT_W-1:0]    ram_wdata, ram_rdata;

    // setup decode
    logic                is_vert, is_horz;
    logic [COORD_W-1:0]  dx_abs, dy_abs;
    logic [COORD_W-1:0]  min_x, min_y;
    logic                on_grid;
    logic [ADDR_W-1:0]   cur_addr;
    logic                cfg_wr;

    // ---------------- config port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diag <= 1'b0;
        end else if (cfg_wr && paddr[2] == REG_INCLUDE_DIAG) begin
            r_diag <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_INCLUDE_DIAG) begin
            prdata[0] = r_diag;
        end
    end

    // ---------------- segment decode ----------------
    assign is_vert = (i_start_x == i_end_x);     // a single point lands here too
    assign is_horz = (i_start_y == i_end_y);
    assign dx_abs  = (i_start_x > i_end_x) ? i_start_x - i_end_x : i_end_x - i_start_x;
    assign dy_abs  = (i_start_y > i_end_y) ? i_start_y - i_end_y : i_end_y - i_start_y;
    assign min_x   = (i_start_x < i_end_x) ? i_start_x : i_end_x;
    assign min_y   = (i_start_y < i_end_y) ? i_start_y : i_end_y;

    // cells off the grid are stepped over but never touched
    assign on_grid = !r_cur_x[POS_W-1] && ({1'b0, r_cur_x} < SIDE_C)
                  && !r_cur_y[POS_W-1] && ({1'b0, r_cur_y} < SIDE_C);
    assign cur_addr = {r_cur_y[CW-1:0], r_cur_x[CW-1:0]};

    assign busy = (r_state != ST_IDLE);

    // ---------------- control ----------------
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_step_x    = r_step_x;
        n_step_y    = r_step_y;
        n_left      = r_left;
        n_s1_vld    = 1'b0;
        n_s1_addr   = r_s1_addr;
        n_out_vld   = 1'b0;
        n_out_total = r_out_total;
        ram_re      = 1'b0;
        ram_raddr   = cur_addr;

        case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (&r_clr_addr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    if (is_vert) begin
                        n_cur_x  = {{(POS_W-COORD_W){1'b0}}, i_start_x};
                        n_cur_y  = {{(POS_W-COORD_W){1'b0}}, min_y};
                        n_step_x = 2'b00;
                        n_step_y = 2'b01;
                        n_left   = dy_abs;
                        n_state  = ST_WALK;
                    end else if (is_horz) begin
                        n_cur_x  = {{(POS_W-COORD_W){1'b0}}, min_x};
                        n_cur_y  = {{(POS_W-COORD_W){1'b0}}, i_start_y};
                        n_step_x = 2'b01;
                        n_step_y = 2'b00;
                        n_left   = dx_abs;
                        n_state  = ST_WALK;
                    end else if (r_diag) begin
                        // y follows x step for step, even past end_y
                        n_cur_x  = {{(POS_W-COORD_W){1'b0}}, i_start_x};
                        n_cur_y  = {{(POS_W-COORD_W){1'b0}}, i_start_y};
                        n_step_x = (i_start_x < i_end_x) ? 2'b01 : 2'b11;
                        n_step_y = (i_start_y < i_end_y) ? 2'b01 : 2'b11;
                        n_left   = dx_abs;
                        n_state  = ST_WALK;
                    end else begin
                        n_state  = ST_FLUSH;
                    end
                end
            end
            ST_WALK: begin
                ram_re    = on_grid;
                n_s1_vld  = on_grid;
                n_s1_addr = cur_addr;
                n_cur_x   = r_cur_x + {{(POS_W-2){r_step_x[1]}}, r_step_x};
                n_cur_y   = r_cur_y + {{(POS_W-2){r_step_y[1]}}, r_step_y};
                if (r_left == '0) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_left = r_left - 1'b1;
                end
            end
            ST_FLUSH: begin
                // last write lands this cycle; n_total already includes it
                n_out_vld   = 1'b1;
                n_out_total = n_total;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---------------- write stage ----------------
    always_comb begin
        n_total   = r_total;
        ram_we    = 1'b0;
        ram_waddr = r_s1_addr;
        ram_wdata = HIT_MULTI;
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = HIT_NONE;
        end else if (r_s1_vld) begin
            ram_we    = 1'b1;
            ram_wdata = (ram_rdata == HIT_NONE) ? HIT_ONCE : HIT_MULTI;
            if (ram_rdata == HIT_ONCE) begin
                n_total = r_total + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_total    <= '0;
            r_s1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_total    <= n_total;
            r_s1_vld   <= n_s1_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_x     <= n_cur_x;
        r_cur_y     <= n_cur_y;
        r_step_x    <= n_step_x;
        r_step_y    <= n_step_y;
        r_left      <= n_left;
        r_s1_addr   <= n_s1_addr;
        r_out_total <= n_out_total;
    end

    assign o_done          = r_out_vld;
    assign o_overlap_cells = r_out_total;

    soc_cell_ram #(
        .ADDR_W (ADDR_W)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // ---------------- assertions ----------------
    // a result only follows the flush step
    `ASSERT_IMPLIES(a_done_after_flush, i_clk, i_rst_n, o_done, $past(r_state == ST_FLUSH))
    // no write-back pending once a new item can be taken
    `ASSERT_IMPLIES(a_idle_no_wb, i_clk, i_rst_n, r_state == ST_IDLE, !r_s1_vld)
    // total moves by at most one cell per cycle
    `ASSERT_IMPLIES(a_total_step, i_clk, i_rst_n, $past(i_rst_n),
        (r_total == $past(r_total)) || (r_total == TOTAL_W'($past(r_total) + 1'b1)))

endmodule

@@ sim/segment_overlap_counter_tb.sv @@
`timescale 1ns / 100ps

module segment_overlap_counter_tb;
    import soc_pkg::*;

    // Grid geometry and run limits
    localparam int GRID_SIDE  = GRID_SIDE_DEF;
    localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
    localparam int CELL_AW    = $clog2(GRID_CELLS);
    localparam int COORD_MAX  = GRID_SIDE - 1;
    // Random segments mostly land in a small window so they cross each other
    localparam int WIN        = 48;
    // Worst case: reset sweep of the whole grid, then ~600 items of up to
    // GRID_SIDE cells each plus sender gaps. Taken ~5x over.
    localparam longint TIMEOUT_NS = 80_000_000;

    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
    } t_segment;

    // DUT ports; every input has a known value from time zero
    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                start     = 1'b0;
    logic                busy;
    logic [COORD_W-1:0]  i_start_x = '0;
    logic [COORD_W-1:0]  i_start_y = '0;
    logic [COORD_W-1:0]  i_end_x   = '0;
    logic [COORD_W-1:0]  i_end_y   = '0;
    logic                o_done;
    logic [TOTAL_W-1:0]  o_overlap_cells;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [APB_AW-1:0]   paddr     = '0;
    logic [APB_DW-1:0]   pwdata    = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // Predictor state: per-cell hit codes, running overlap count, mode bit
    bit   [HIT_W-1:0]    cell_count [GRID_CELLS];
    logic [TOTAL_W-1:0]  overlap_count  = '0;
    bit                  diag_enabled   = 1'b0;

    // Overlap totals waiting for their o_done strobe, oldest first
    logic [TOTAL_W-1:0]  expected_totals [$];
    int                  mismatches = 0;

    segment_overlap_counter #(
        .GRID_SIDE(GRID_SIDE)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .o_done         (o_done),
        .o_overlap_cells(o_overlap_cells),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // One cell of the walk. Off-grid cells (only reachable by a skewed
    // diagonal running past the edge) are dropped; the count only moves
    // on the once -> multi transition, multi stays saturated.
    function automatic void mark_cell(input int x, input int y);
        logic [CELL_AW-1:0] idx;
        if (x < 0 || y < 0 || x >= GRID_SIDE || y >= GRID_SIDE) begin
            return;
        end
        idx = CELL_AW'(x + y * GRID_SIDE);
        if (cell_count[idx] == HIT_NONE) begin
            cell_count[idx] = HIT_ONCE;
        end else if (cell_count[idx] == HIT_ONCE) begin
            cell_count[idx] = HIT_MULTI;
            overlap_count = overlap_count + 1'b1;
        end
    endfunction

    // Rasterize one segment and return the running overlap count after it.
    // Vertical wins when both ends coincide (single cell). A diagonal walks
    // |dx|+1 cells with y stepping every time, even past end_y.
    function automatic logic [TOTAL_W-1:0] count_overlaps(input t_segment s);
        int x1, y1, x2, y2, lo, hi, sx, sy, len;
        x1 = s.start_x;
        y1 = s.start_y;
        x2 = s.end_x;
        y2 = s.end_y;
        if (x1 == x2) begin
            lo = (y1 < y2) ? y1 : y2;
            hi = (y1 < y2) ? y2 : y1;
            for (int i = lo; i <= hi; i++) mark_cell(x1, i);
        end else if (y1 == y2) begin
            lo = (x1 < x2) ? x1 : x2;
            hi = (x1 < x2) ? x2 : x1;
            for (int i = lo; i <= hi; i++) mark_cell(i, y1);
        end else if (diag_enabled) begin
            sx  = (x1 < x2) ? 1 : -1;
            sy  = (y1 < y2) ? 1 : -1;
            len = (x1 < x2) ? x2 - x1 : x1 - x2;
            for (int i = 0; i <= len; i++) mark_cell(x1 + i * sx, y1 + i * sy);
        end
        return overlap_count;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every o_done must match the oldest prediction.
    // Outputs are sampled before the edge's updates land.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_totals.size() == 0) begin
                report_mismatch($sformatf("unexpected result overlap_cells=%0d",
                                          o_overlap_cells));
            end else if (o_overlap_cells !== expected_totals[0]) begin
                report_mismatch($sformatf("overlap_cells got %0d exp %0d",
                                          o_overlap_cells, expected_totals[0]));
                void'(expected_totals.pop_front());
            end else begin
                void'(expected_totals.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver side
    // ------------------------------------------------------------------

    // Present one segment and hold it until taken (start high, busy low).
    // start is left high so a following item can go back to back.
    task automatic send_segment(input t_segment s);
        logic [TOTAL_W-1:0] exp_total;
        start     <= 1'b1;
        i_start_x <= s.start_x;
        i_start_y <= s.start_y;
        i_end_x   <= s.end_x;
        i_end_y   <= s.end_y;
        do @(posedge i_clk); while (busy);
        exp_total       = count_overlaps(s);
        expected_totals = {expected_totals, exp_total};
    endtask

    task automatic send_xy(input int x1, input int y1, input int x2, input int y2);
        t_segment s;
        s.start_x = COORD_W'(x1);
        s.start_y = COORD_W'(y1);
        s.end_x   = COORD_W'(x2);
        s.end_y   = COORD_W'(y2);
        send_segment(s);
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Stop sending and wait until every predicted result has been seen
    task automatic wait_results_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_totals.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // APB write of the mode register, then a read back of it.
    // Only called with nothing in flight.
    task automatic set_include_diagonals(input bit value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_INCLUDE_DIAG, 2'b00};
        pwdata  <= {{(APB_DW-1){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        diag_enabled = value;
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[0] !== value) begin
            report_mismatch($sformatf("include_diagonals read %0b exp %0b",
                                      prdata[0], value));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Random segment generation
    // ------------------------------------------------------------------

    // Move d away from v in a random direction, staying on the grid
    function automatic int step_coord(input int v, input int d);
        if ($urandom_range(0, 1)) begin
            if (v + d <= COORD_MAX) return v + d;
            return v - d;
        end
        if (v - d >= 0) return v - d;
        return v + d;
    endfunction

    function automatic int window_base();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return GRID_SIDE - WIN;
            default: return $urandom_range(0, GRID_SIDE - WIN);
        endcase
    endfunction

    // Mostly short segments in small windows (edges included, so skewed
    // diagonals run off the grid); a few long ones from a grid edge.
    function automatic t_segment random_segment();
        t_segment s;
        int x1, y1, x2, y2, len, kind;
        x1   = window_base() + $urandom_range(0, WIN - 1);
        y1   = window_base() + $urandom_range(0, WIN - 1);
        len  = $urandom_range(0, WIN / 2);
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 3) begin
            x1 = $urandom_range(0, COORD_MAX);
            y1 = $urandom_range(0, COORD_MAX);
            case ($urandom_range(0, 2))
                0: begin x2 = COORD_MAX - x1; x1 = 0; y2 = y1; end
                1: begin y2 = COORD_MAX - y1; y1 = 0; x2 = x1; end
                default: begin x1 = 0; x2 = COORD_MAX; y2 = $urandom_range(0, COORD_MAX); end
            endcase
            if ($urandom_range(0, 1)) begin
                x1 = x1 ^ x2; x2 = x1 ^ x2; x1 = x1 ^ x2;
                y1 = y1 ^ y2; y2 = y1 ^ y2; y1 = y1 ^ y2;
            end
        end else if (kind < 10) begin
            x2 = x1;
            y2 = y1;
        end else if (kind < 35) begin
            x2 = step_coord(x1, len);
            y2 = y1;
        end else if (kind < 60) begin
            x2 = x1;
            y2 = step_coord(y1, len);
        end else if (kind < 85) begin
            // 45-degree diagonal
            x2 = step_coord(x1, len);
            y2 = step_coord(y1, (x2 > x1) ? x2 - x1 : x1 - x2);
        end else begin
            // skewed diagonal
            x2 = step_coord(x1, len);
            y2 = step_coord(y1, $urandom_range(1, WIN / 2));
        end
        s.start_x = COORD_W'(x1);
        s.start_y = COORD_W'(y1);
        s.end_x   = COORD_W'(x2);
        s.end_y   = COORD_W'(y2);
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset; the mode register is written during the clear sweep
    task automatic test_reset();
        i_rst_n <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_include_diagonals(1'b0);
    endtask

    // Single points, full rows/columns along all four grid edges, both
    // directions; corner cells get hit two, three and four times.
    task automatic test_axis_segments();
        send_xy(0, 0, 0, 0);
        send_xy(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_xy(COORD_MAX, 0, 0, 0);
        send_xy(0, 0, 0, COORD_MAX);
        send_xy(COORD_MAX, COORD_MAX, COORD_MAX, 0);
        send_xy(0, COORD_MAX, COORD_MAX, COORD_MAX);
        send_xy(0, 0, 0, 0);
        send_xy(512, 7, 512, 7);
    endtask

    // Diagonals with the mode bit clear: no change, total still returned
    task automatic test_diagonals_ignored();
        send_xy(0, 0, COORD_MAX, COORD_MAX);
        send_xy(5, 9, 20, 3);
        send_xy(COORD_MAX, 0, 0, COORD_MAX);
        wait_results_drained();
    endtask

    // Full diagonals both ways, skewed walks leaving the grid at the bottom
    // and top, a steep one that covers only |dx|+1 cells
    task automatic test_diagonal_walks();
        set_include_diagonals(1'b1);
        send_xy(0, 0, COORD_MAX, COORD_MAX);
        send_xy(COORD_MAX, 0, 0, COORD_MAX);
        send_xy(0, 5, 40, 0);
        send_xy(1000, 1020, COORD_MAX, 1022);
        send_xy(30, 2, 2, 3);
        send_xy(10, 10, 12, 50);
        send_xy(600, 600, 590, 610);
    endtask

    // Same row three times plus a crossing column: count rises once per cell
    task automatic test_saturation();
        send_xy(100, 200, 140, 200);
        send_xy(140, 200, 100, 200);
        send_xy(100, 200, 140, 200);
        send_xy(120, 180, 120, 220);
    endtask

    // Random segments; optional sender gaps and an optional full drain midway
    task automatic test_random_segments(input int count, input bit with_gaps,
                                        input bit with_drain);
        for (int i = 0; i < count; i++) begin
            if (with_drain && i == count / 2) wait_results_drained();
            if (with_gaps && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 3));
            send_segment(random_segment());
        end
        wait_results_drained();
    endtask

    initial begin
        test_reset();
        test_axis_segments();
        test_diagonals_ignored();
        test_diagonal_walks();
        test_saturation();
        wait_results_drained();
        test_random_segments(200, 1'b1, 1'b1);
        set_include_diagonals(1'b0);
        test_random_segments(150, 1'b1, 1'b0);
        set_include_diagonals(1'b1);
        // last part runs with no sender gaps
        test_random_segments(230, 1'b0, 1'b0);
        repeat (GRID_SIDE + 8) @(posedge i_clk);
        if (expected_totals.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_totals.size()));
        end
        if (mismatches == 0) begin
            $display("** segment_overlap_counter: PASSED **");
        end else begin
            $display("** segment_overlap_counter: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("TIMEOUT: run did not finish");
        $display("** segment_overlap_counter: FAILED **");
        $finish;
    end

endmodule

@@ segment_overlap_counter.f @@
+incdir+hw/rtl
hw/rtl/soc_pkg.sv
hw/rtl/soc_cell_ram.sv
hw/rtl/segment_overlap_counter.sv
sim/segment_overlap_counter_tb.sv
